// ----- hdl/rau_pkg.sv -----
// ----------------------------------------------------------------------------
// rau_pkg: shared types and codes for the rational arithmetic unit
// Command and status codes, the classified item handed from front to back.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int unsigned MagBits = 64;

  typedef enum logic [2:0] {
    CMD_ADD  = 3'd0,
    CMD_SUB  = 3'd1,
    CMD_MUL  = 3'd2,
    CMD_DIV  = 3'd3,
    CMD_CMP  = 3'd4,
    CMD_INC  = 3'd5,
    CMD_DEC  = 3'd6,
    CMD_NOP  = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DIVZERO = 2'd1,
    ST_ZERODEN = 2'd2,
    ST_OVF     = 2'd3
  } status_e;

  // classified item: either an early result (error, nop or compare) or a pending reduction
  typedef struct packed {
    logic        early;     // result fixed in the front
    status_e     status;
    logic        is_cmp;
    logic        lt;
    logic        eq;
    logic        gt;
    logic        n_neg;
    logic [MagBits-1:0] n_mag;
    logic        d_neg;
    logic [MagBits-1:0] d_mag;
  } item_t;

  typedef struct packed {
    logic [31:0] num;
    logic [30:0] den;
    status_e     status;
    logic        lt;
    logic        eq;
    logic        gt;
  } res_t;

endpackage

// ----- hdl/rational_arithmetic_unit.sv -----
// ----------------------------------------------------------------------------
// rational_arithmetic_unit: fraction ALU with gcd reduction
// Add, sub, mul, div, compare, increment and decrement on 32-bit fractions.
// ----------------------------------------------------------------------------
//  channel  dir  tdata fields (low bit first)               tuser
//  s_axis   in   cmd, a_num, a_den, b_num, b_den (136 bits)  -
//  m_axis   out  res_num, res_den, status, lt, eq, gt (72)   -
// The front does up to three serial 32x32 multiplies per item, and the back
// runs a binary gcd one step per cycle, then divides both parts by it;
// errors, nops, compares and zero numerators skip the gcd and division.
// Reset is asynchronous; a two-entry queue lets front and back stall apart.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [135:0] s_axis_tdata,  // cmd, a_num, a_den, b_num, b_den
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [71:0]  m_axis_tdata   // res_num, res_den, status, lt, eq, gt
);
  import rau_pkg::*;

  logic f_valid, f_ready, q_valid, q_ready;
  item_t f_item, q_item;
  res_t res;

  rau_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .cmd_i      (s_axis_tdata[2:0]),
    .a_num_i    (s_axis_tdata[34:3]),
    .a_den_i    (s_axis_tdata[66:35]),
    .b_num_i    (s_axis_tdata[98:67]),
    .b_den_i    (s_axis_tdata[130:99]),
    .out_valid_o(f_valid),
    .out_ready_i(f_ready),
    .item_o     (f_item)
  );

  rau_fifo u_fifo (
    .clk_i, .rst_ni,
    .in_valid_i (f_valid), .in_ready_o (f_ready), .in_item_i (f_item),
    .out_valid_o(q_valid), .out_ready_i(q_ready), .out_item_o(q_item)
  );

  rau_back #(.WordBits(WORD_BITS)) u_back (
    .clk_i, .rst_ni,
    .in_valid_i (q_valid), .in_ready_o (q_ready), .item_i (q_item),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .res_o (res)
  );

  assign m_axis_tdata = {4'd0, res.gt, res.eq, res.lt, res.status, res.den, res.num};

endmodule

// ----- hdl/rau_front.sv -----
// ----------------------------------------------------------------------------
// rau_front: operand intake and classification
// Decodes the command, catches error cases and forms the cross products
// (one 32x32 multiply per cycle), the signed sums of the numerator and compares.
// ----------------------------------------------------------------------------
module rau_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [2:0]          cmd_i,
  input  logic [31:0]         a_num_i,
  input  logic [31:0]         a_den_i,
  input  logic [31:0]         b_num_i,
  input  logic [31:0]         b_den_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rau_pkg::item_t      item_o
);
  import rau_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_M0, S_M1, S_M2, S_SUM, S_OUT} state_e;

  state_e state_q;
  logic [2:0] cmd_q;
  logic an_s_q, ad_s_q, bn_s_q, bd_s_q;
  logic [31:0] an_q, ad_q, bn_q, bd_q;
  logic [63:0] p_q, q_q, r_q;
  logic p_s_q, q_s_q, r_s_q;
  item_t item_q;

  logic [31:0] ma, mb;
  logic ms_a, ms_b;
  logic [63:0] prod;

  function automatic logic [31:0] mag32(input logic [31:0] x);
    return x[31] ? (~x + 32'd1) : x;
  endfunction

  // signed-magnitude add, result sign cleared on zero
  function automatic logic [64:0] sm_add(input logic sa, input logic [63:0] a,
                                         input logic sb, input logic [63:0] b);
    logic [63:0] m;
    logic s;
    if (sa == sb) begin
      m = a + b; s = sa;
    end else if (a >= b) begin
      m = a - b; s = sa;
    end else begin
      m = b - a; s = sb;
    end
    return {s && (m != 64'd0), m};
  endfunction

  always_comb begin
    ma = an_q; mb = bd_q; ms_a = an_s_q; ms_b = bd_s_q;
    case (state_q)
      S_M0: begin
        ma = an_q; ms_a = an_s_q;
        if (cmd_q == CMD_MUL) begin mb = bn_q; ms_b = bn_s_q; end
        else begin mb = bd_q; ms_b = bd_s_q; end
      end
      S_M1: begin
        ma = ad_q; ms_a = ad_s_q;
        if (cmd_q == CMD_MUL) begin mb = bd_q; ms_b = bd_s_q; end
        else begin mb = bn_q; ms_b = bn_s_q; end
      end
      S_M2: begin
        ma = ad_q; ms_a = ad_s_q;
        if (cmd_q == CMD_DIV) begin mb = bn_q; ms_b = bn_s_q; end
        else begin mb = bd_q; ms_b = bd_s_q; end
      end
      default: ;
    endcase
    prod = 64'(ma) * 64'(mb);
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign item_o      = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic [64:0] sm;
    logic [63:0] pm, qm;
    logic ps, qs;
    item_t it;
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            cmd_q  <= cmd_i;
            an_q   <= mag32(a_num_i); an_s_q <= a_num_i[31];
            ad_q   <= mag32(a_den_i); ad_s_q <= a_den_i[31];
            bn_q   <= mag32(b_num_i); bn_s_q <= b_num_i[31];
            bd_q   <= mag32(b_den_i); bd_s_q <= b_den_i[31];
            it = '0;
            it.early = 1'b1;
            if (cmd_i == CMD_NOP) begin
              state_q <= S_OUT;
            end else if (a_den_i == 32'd0 ||
                         (cmd_i <= CMD_CMP && b_den_i == 32'd0)) begin
              it.status = ST_ZERODEN;
              state_q <= S_OUT;
            end else if (cmd_i == CMD_DIV && b_num_i == 32'd0) begin
              it.status = ST_DIVZERO;
              state_q <= S_OUT;
            end else if (cmd_i == CMD_INC || cmd_i == CMD_DEC) begin
              state_q <= S_SUM;
            end else begin
              state_q <= S_M0;
            end
            item_q <= it;
          end
        end
        S_M0: begin
          p_q <= prod; p_s_q <= (prod != 64'd0) && (ms_a != ms_b);
          state_q <= S_M1;
        end
        S_M1: begin
          q_q <= prod; q_s_q <= (prod != 64'd0) && (ms_a != ms_b);
          state_q <= (cmd_q == CMD_CMP) ? S_SUM : S_M2;
        end
        S_M2: begin
          r_q <= prod; r_s_q <= (prod != 64'd0) && (ms_a != ms_b);
          state_q <= S_SUM;
        end
        S_SUM: begin
          it = item_q;
          it.early = 1'b0;
          it.is_cmp = 1'b0;
          it.d_neg = r_s_q; it.d_mag = r_q;
          case (cmd_q)
            CMD_ADD: begin
              sm = sm_add(p_s_q, p_q, q_s_q, q_q);
              it.n_neg = sm[64]; it.n_mag = sm[63:0];
            end
            CMD_SUB: begin
              sm = sm_add(p_s_q, p_q, (q_q != 64'd0) && !q_s_q, q_q);
              it.n_neg = sm[64]; it.n_mag = sm[63:0];
            end
            CMD_MUL: begin
              // MUL used p = an*bn as numerator, q = ad*bd as denominator
              it.n_neg = p_s_q; it.n_mag = p_q;
              it.d_neg = q_s_q; it.d_mag = q_q;
            end
            CMD_DIV: begin
              it.n_neg = p_s_q; it.n_mag = p_q;
            end
            CMD_CMP: begin
              pm = p_q; qm = q_q;
              ps = p_s_q; qs = q_s_q;
              if (ad_s_q != bd_s_q) begin
                ps = (pm != 64'd0) && !ps;
                qs = (qm != 64'd0) && !qs;
              end
              it.early  = 1'b1;
              it.is_cmp = 1'b1;
              if (ps != qs) begin
                it.lt = ps; it.gt = !ps;
              end else if (pm == qm) begin
                it.eq = 1'b1;
              end else begin
                it.lt = ps ? (pm > qm) : (pm < qm);
                it.gt = ps ? (pm < qm) : (pm > qm);
              end
            end
            CMD_INC: begin
              sm = sm_add(an_s_q, 64'(an_q), ad_s_q, 64'(ad_q));
              it.n_neg = sm[64]; it.n_mag = sm[63:0];
              it.d_neg = ad_s_q; it.d_mag = 64'(ad_q);
            end
            default: begin
              sm = sm_add(an_s_q, 64'(an_q), !ad_s_q, 64'(ad_q));
              it.n_neg = sm[64]; it.n_mag = sm[63:0];
              it.d_neg = ad_s_q; it.d_mag = 64'(ad_q);
            end
          endcase
          item_q <= it;
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_ready_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hdl/rau_fifo.sv -----
// ----------------------------------------------------------------------------
// rau_fifo: small queue between front and back
// Two-entry register queue of classified items.
// ----------------------------------------------------------------------------
module rau_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  rau_pkg::item_t in_item_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output rau_pkg::item_t out_item_o
);
  import rau_pkg::*;

  item_t mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_item_o  = mem_q[rp_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= !wp_q;
      if (pop) rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

endmodule

// ----- hdl/rau_back.sv -----
// ----------------------------------------------------------------------------
// rau_back: reduction engine
// Binary gcd one step per cycle, then two restoring dividers in parallel,
// one quotient bit per cycle, then sign and range check.
// ----------------------------------------------------------------------------
module rau_back #(
  parameter int unsigned WordBits = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  rau_pkg::item_t item_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output rau_pkg::res_t  res_o
);
  import rau_pkg::*;

  localparam logic [63:0] Lim = 64'd1 << (WordBits - 1);

  typedef enum logic [2:0] {S_IDLE, S_TWO, S_ODD, S_SUB, S_DIV, S_CHK, S_OUT} state_e;

  state_e state_q;
  logic [63:0] ga_q, gb_q, g_q, nm_q, dm_q, nq_q, dq_q, nr_q, dr_q;
  logic [5:0] k_q, bit_q;
  logic neg_q;
  res_t res_q;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic [64:0] nt, dt;
    logic [63:0] nq, dq;
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            res_q.num <= '0; res_q.den <= 31'd1;
            res_q.status <= item_i.status;
            res_q.lt <= item_i.lt; res_q.eq <= item_i.eq; res_q.gt <= item_i.gt;
            nm_q <= item_i.n_mag; dm_q <= item_i.d_mag;
            ga_q <= item_i.n_mag; gb_q <= item_i.d_mag;
            neg_q <= item_i.n_neg != item_i.d_neg;
            k_q <= '0;
            if (item_i.early || item_i.n_mag == 64'd0) state_q <= S_OUT;
            else state_q <= S_TWO;
          end
        end
        S_TWO: begin
          if (ga_q[0] == 1'b0 && gb_q[0] == 1'b0) begin
            ga_q <= ga_q >> 1; gb_q <= gb_q >> 1; k_q <= k_q + 6'd1;
          end else begin
            state_q <= S_ODD;
          end
        end
        S_ODD: begin
          if (!ga_q[0]) ga_q <= ga_q >> 1;
          else if (!gb_q[0]) gb_q <= gb_q >> 1;
          else state_q <= S_SUB;
        end
        S_SUB: begin
          if (!gb_q[0]) begin
            gb_q <= gb_q >> 1;
          end else if (ga_q == gb_q) begin
            g_q <= ga_q << k_q;
            nq_q <= '0; dq_q <= '0; nr_q <= '0; dr_q <= '0;
            bit_q <= 6'd63;
            state_q <= S_DIV;
          end else if (ga_q > gb_q) begin
            ga_q <= gb_q; gb_q <= ga_q - gb_q;
          end else begin
            gb_q <= gb_q - ga_q;
          end
        end
        S_DIV: begin
          nt = {nr_q, nm_q[bit_q]};
          dt = {dr_q, dm_q[bit_q]};
          nq = nq_q; dq = dq_q;
          if (nt >= {1'b0, g_q}) begin nt = nt - {1'b0, g_q}; nq[bit_q] = 1'b1; end
          if (dt >= {1'b0, g_q}) begin dt = dt - {1'b0, g_q}; dq[bit_q] = 1'b1; end
          nr_q <= nt[63:0]; dr_q <= dt[63:0]; nq_q <= nq; dq_q <= dq;
          bit_q <= bit_q - 6'd1;
          if (bit_q == 6'd0) state_q <= S_CHK;
        end
        S_CHK: begin
          if (dq_q > Lim - 64'd1 || nq_q > (neg_q ? Lim : Lim - 64'd1)) begin
            res_q.status <= ST_OVF;
          end else begin
            res_q.num <= neg_q ? (32'd0 - nq_q[31:0]) : nq_q[31:0];
            res_q.den <= dq_q[30:0];
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_ready_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- verif/rational_arithmetic_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_tb: self-checking bench for the fraction ALU
// Drives command beats with random idling, predicts each reduced fraction or
// compare outcome and checks every result beat in order.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_tb;
  import rau_pkg::*;

  typedef struct {
    logic [31:0] num;
    logic [30:0] den;
    status_e     status;
    logic        lt;
    logic        eq;
    logic        gt;
  } frac_res_t;

  class frac_scoreboard;
    frac_res_t pending[$];
    int errors;
    int mismatches;

    function void note_input(frac_res_t r);
      pending.push_back(r);
    endfunction

    function void check_result(logic [71:0] d);
      frac_res_t e;
      logic [31:0] num;
      logic [30:0] den;
      logic [1:0]  st;
      num = d[31:0];
      den = d[62:32];
      st  = d[64:63];
      if (pending.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected result beat %h", d);
        return;
      end
      e = pending.pop_front();
      if (num !== e.num || den !== e.den || st !== e.status || d[65] !== e.lt ||
          d[66] !== e.eq || d[67] !== e.gt) begin
        errors++;
        if (mismatches++ < 10)
          $display("mismatch: exp %0d/%0d st%0d %b%b%b, got %0d/%0d st%0d %b%b%b",
                   $signed(e.num), e.den, e.status, e.lt, e.eq, e.gt,
                   $signed(num), den, st, d[65], d[66], d[67]);
      end
    endfunction
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [135:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [71:0]  m_axis_tdata;

  frac_scoreboard sb;
  bit quiet = 0;
  int idle_cycles = 0;

  always #4 clk_i = ~clk_i;

  rational_arithmetic_unit DUT (.*);

  // signed-magnitude helpers at 64 bits plus sign
  function automatic logic [64:0] sm_of(logic [31:0] x);
    logic [63:0] m;
    m = x[31] ? {32'd0, -x} : {32'd0, x};
    return {x[31], m};
  endfunction

  function automatic logic [64:0] sm_mult(logic [64:0] a, logic [64:0] b);
    logic [63:0] m;
    m = a[63:0] * b[63:0];
    return {(m != 0) && (a[64] != b[64]), m};
  endfunction

  function automatic logic [64:0] sm_sum(logic [64:0] a, logic [64:0] b);
    logic [63:0] m;
    logic s;
    if (a[64] == b[64]) begin
      m = a[63:0] + b[63:0]; s = a[64];
    end else if (a[63:0] >= b[63:0]) begin
      m = a[63:0] - b[63:0]; s = a[64];
    end else begin
      m = b[63:0] - a[63:0]; s = b[64];
    end
    return {s && m != 0, m};
  endfunction

  function automatic logic [64:0] sm_negate(logic [64:0] a);
    return {a[64] ^ (a[63:0] != 0), a[63:0]};
  endfunction

  function automatic logic [63:0] gcd_of(logic [63:0] a, logic [63:0] b);
    logic [63:0] t;
    while (b != 0) begin
      t = a % b; a = b; b = t;
    end
    return a;
  endfunction

  function automatic frac_res_t reduce(logic [64:0] n, logic [64:0] d);
    frac_res_t r;
    logic [63:0] g, nm, dm;
    logic neg;
    r = '{32'd0, 31'd1, ST_OK, 1'b0, 1'b0, 1'b0};
    if (n[63:0] == 0) return r;
    neg = n[64] != d[64];
    g = gcd_of(n[63:0], d[63:0]);
    nm = n[63:0] / g;
    dm = d[63:0] / g;
    if (dm > 64'h7fff_ffff || nm > (neg ? 64'h8000_0000 : 64'h7fff_ffff)) begin
      r.status = ST_OVF;
      return r;
    end
    r.num = neg ? -nm[31:0] : nm[31:0];
    r.den = dm[30:0];
    return r;
  endfunction

  function automatic frac_res_t predict_fraction(cmd_e c, logic [31:0] an_i,
      logic [31:0] ad_i, logic [31:0] bn_i, logic [31:0] bd_i);
    frac_res_t r;
    logic [64:0] an, ad, bn, bd, p, q;
    an = sm_of(an_i); ad = sm_of(ad_i); bn = sm_of(bn_i); bd = sm_of(bd_i);
    r = '{32'd0, 31'd1, ST_OK, 1'b0, 1'b0, 1'b0};
    if (c == CMD_NOP) return r;
    if (ad[63:0] == 0 || (c <= CMD_CMP && bd[63:0] == 0)) begin
      r.status = ST_ZERODEN;
      return r;
    end
    case (c)
      CMD_ADD: r = reduce(sm_sum(sm_mult(an, bd), sm_mult(bn, ad)), sm_mult(ad, bd));
      CMD_SUB: r = reduce(sm_sum(sm_mult(an, bd), sm_negate(sm_mult(bn, ad))),
                          sm_mult(ad, bd));
      CMD_MUL: r = reduce(sm_mult(an, bn), sm_mult(ad, bd));
      CMD_DIV: begin
        if (bn[63:0] == 0) r.status = ST_DIVZERO;
        else r = reduce(sm_mult(an, bd), sm_mult(ad, bn));
      end
      CMD_CMP: begin
        p = sm_mult(an, bd);
        q = sm_mult(bn, ad);
        if (ad[64] != bd[64]) begin
          p = sm_negate(p); q = sm_negate(q);
        end
        if (p == q) r.eq = 1'b1;
        else if (p[64] != q[64]) r.lt = p[64];
        else r.lt = p[64] ? (p[63:0] > q[63:0]) : (p[63:0] < q[63:0]);
        r.gt = !r.lt && !r.eq;
      end
      CMD_INC: r = reduce(sm_sum(an, ad), ad);
      default: r = reduce(sm_sum(an, sm_negate(ad)), ad);
    endcase
    return r;
  endfunction

  task automatic send_item(cmd_e c, logic [31:0] an, logic [31:0] ad,
                           logic [31:0] bn, logic [31:0] bd);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {5'd0, bd, bn, ad, an, c};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_input(predict_fraction(c, an, ad, bn, bd));
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 20);
      1: return -$urandom_range(0, 20);
      2: return $urandom_range(0, 5000);
      3: return -$urandom_range(0, 5000);
      4: return {$urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff};
      default: return $urandom;
    endcase
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    int stall;
    forever begin
      @(posedge clk_i);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 10);
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  initial begin
    logic [31:0] ex[6];
    sb = new();
    ex = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h1, 32'hffff_ffff, 32'h3};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int c = 0; c < 8; c++) send_item(cmd_e'(c), 32'd3, 32'd4, -32'd5, 32'd6);
    send_item(CMD_ADD, 32'd1, 32'd0, 32'd1, 32'd1);
    send_item(CMD_INC, 32'd1, 32'd0, 32'd1, 32'd0);
    send_item(CMD_DEC, 32'd1, 32'd2, 32'd1, 32'd0);
    send_item(CMD_CMP, 32'd1, 32'd2, 32'd1, 32'd0);
    send_item(CMD_DIV, 32'd1, 32'd2, 32'd0, 32'd3);
    send_item(CMD_DIV, 32'd1, 32'd0, 32'd0, 32'd3);
    send_item(CMD_SUB, 32'd2, 32'd3, 32'd2, 32'd3);
    send_item(CMD_CMP, 32'd2, -32'd3, -32'd4, 32'd6);
    send_item(CMD_CMP, 32'd1, -32'd3, 32'd1, 32'd3);
    send_item(CMD_MUL, 32'h7fff_ffff, 32'd1, 32'h7fff_ffff, 32'd1);
    send_item(CMD_DIV, 32'h8000_0000, 32'd1, 32'hffff_ffff, 32'd1);
    send_item(CMD_MUL, 32'h8000_0000, 32'd1, 32'd1, 32'd1);
    send_item(CMD_DEC, 32'h8000_0000, 32'd1, 32'd0, 32'd0);
    send_item(CMD_INC, 32'h7fff_ffff, 32'd1, 32'd0, 32'd0);
    send_item(CMD_ADD, 32'd1, 32'h8000_0000, 32'd1, 32'h8000_0000);
    for (int i = 0; i < 1300; i++) begin
      if (i == 600) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
        while (sb.pending.size() != 0) @(posedge clk_i);
      end
      if (i == 1150) quiet = 1;
      if (i < 36)
        send_item(cmd_e'(i % 7), ex[i % 6], ex[(i / 6) % 6] | 32'd1, ex[(i + 2) % 6],
                  ex[(i + 3) % 6] | 32'd1);
      else
        send_item(cmd_e'($urandom_range(0, 7)), rand_word(),
                  $urandom_range(0, 40) == 0 ? 32'd0 : rand_word(), rand_word(),
                  $urandom_range(0, 40) == 0 ? 32'd0 : rand_word());
    end
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
